/* sv/afr_pkg.sv */
// afr_pkg: shared types and constants of the addressed frame receiver.
// No dependencies; imported by every afr module.
`default_nettype none

package afr_pkg;

   localparam int MaxPayload = 512;
   localparam int CountWidth = $clog2(MaxPayload + 1);
   localparam int LenWidth   = 16;
   localparam int IndexWidth = 9;
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FillWidth  = $clog2(QueueDepth + 1);

   localparam logic [7:0] MarkFirst  = 8'h23;
   localparam logic [7:0] MarkSecond = 8'h21;

   localparam logic [1:0] RegOwnAddress  = 2'd0;
   localparam logic [1:0] RegSourceLimit = 2'd1;
   localparam logic [1:0] RegFirstTarget = 2'd2;
   localparam logic [1:0] RegSecondTarget = 2'd3;

   localparam logic [1:0] TargetNone   = 2'd0;
   localparam logic [1:0] TargetFirst  = 2'd1;
   localparam logic [1:0] TargetSecond = 2'd2;

   typedef enum logic [2:0] {
      PhaseHunt,
      PhaseMark2,
      PhaseDest,
      PhaseSource,
      PhaseLenHigh,
      PhaseLenLow,
      PhasePayload
   } afr_phase_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic [7:0] source_limit;
      logic [7:0] first_target_source;
      logic [7:0] second_target_source;
   } afr_cfg_type;

   typedef struct packed {
      logic [7:0]            payload_byte;
      logic [7:0]            frame_source;
      logic [IndexWidth-1:0] payload_index;
      logic                  last_of_frame;
   } afr_entry_type;

endpackage

`default_nettype wire

/* sv/afr_front.sv */
// afr_front: frame parser; hunts for the header and emits one entry per payload byte.
// Depends on afr_pkg.
`default_nettype none

module afr_front
   import afr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    rx_byte,
   input  wire afr_cfg_type   cfg,
   output      logic          push,
   output      afr_entry_type entry
);

   afr_phase_type         phase_ff, phase_in;
   logic [7:0]            source_ff, source_in;
   logic [7:0]            len_high_ff, len_high_in;
   logic [CountWidth-1:0] length_ff, length_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [LenWidth-1:0]   frame_len;
   logic [CountWidth-1:0] count_next;
   logic                  last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhaseHunt;
         source_ff   <= '0;
         len_high_ff <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         source_ff   <= source_in;
         len_high_ff <= len_high_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      source_in   = source_ff;
      len_high_in = len_high_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      frame_len   = {len_high_ff, rx_byte};
      count_next  = count_ff + CountWidth'(1);
      last        = LenWidth'(count_next) >= LenWidth'(length_ff);
      push        = 1'b0;
      entry.payload_byte  = rx_byte;
      entry.frame_source  = source_ff;
      entry.payload_index = count_ff[IndexWidth-1:0];
      entry.last_of_frame = last;
      if (step) begin
         case (phase_ff)
            PhaseHunt: begin
               phase_in = (rx_byte == MarkFirst) ? PhaseMark2 : PhaseHunt;
            end
            PhaseMark2: begin
               phase_in = (rx_byte == MarkSecond) ? PhaseDest : PhaseHunt;
            end
            PhaseDest: begin
               phase_in = (rx_byte == cfg.own_address) ? PhaseSource : PhaseHunt;
            end
            PhaseSource: begin
               if (rx_byte < cfg.source_limit) begin
                  source_in = rx_byte;
                  phase_in  = PhaseLenHigh;
               end else begin
                  phase_in = PhaseHunt;
               end
            end
            PhaseLenHigh: begin
               len_high_in = rx_byte;
               phase_in    = PhaseLenLow;
            end
            PhaseLenLow: begin
               if (frame_len == '0 || frame_len > LenWidth'(MaxPayload)) begin
                  phase_in    = PhaseHunt;
                  source_in   = '0;
                  len_high_in = '0;
                  length_in   = '0;
                  count_in    = '0;
               end else begin
                  length_in = frame_len[CountWidth-1:0];
                  phase_in  = PhasePayload;
               end
            end
            PhasePayload: begin
               push     = 1'b1;
               count_in = count_next;
               if (last) begin
                  phase_in    = PhaseHunt;
                  source_in   = '0;
                  len_high_in = '0;
                  length_in   = '0;
                  count_in    = '0;
               end
            end
            default: begin
               phase_in = (rx_byte == MarkFirst) ? PhaseMark2 : PhaseHunt;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* sv/afr_queue.sv */
// afr_queue: short register queue between parser and output stage.
// Depends on afr_pkg.
`default_nettype none

module afr_queue
   import afr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire afr_entry_type push_entry,
   input  wire logic          pop,
   output      logic          full,
   output      logic          head_valid,
   output      afr_entry_type head_entry
);

   afr_entry_type         slot_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] ptr);
      logic [PtrWidth-1:0] result;
      result = (ptr == PtrWidth'(QueueDepth - 1)) ? '0 : ptr + PtrWidth'(1);
      return result;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      full       = fill_ff == FillWidth'(QueueDepth);
      head_valid = fill_ff != '0;
      head_entry = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in    = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FillWidth'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FillWidth'(1);
      end
   end

endmodule

`default_nettype wire

/* sv/afr_back.sv */
// afr_back: output stage; resolves the delivery target and holds the result word.
// Depends on afr_pkg.
`default_nettype none

module afr_back
   import afr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire afr_cfg_type           cfg,
   input  wire logic                  head_valid,
   input  wire afr_entry_type         head_entry,
   output      logic                  pop,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [7:0]            rsp_payload_byte,
   output      logic [7:0]            rsp_frame_source,
   output      logic [IndexWidth-1:0] rsp_payload_index,
   output      logic [1:0]            rsp_delivery_target,
   output      logic                  rsp_last_of_frame
);

   logic                  valid_ff, valid_in;
   afr_entry_type         word_ff;
   logic [1:0]            target_ff, target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff   <= head_entry;
         target_ff <= target_in;
      end
   end

   always_comb begin
      pop = head_valid && (!valid_ff || !rsp_stall);
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      if (head_entry.frame_source == cfg.first_target_source) begin
         target_in = TargetFirst;
      end else if (head_entry.frame_source == cfg.second_target_source) begin
         target_in = TargetSecond;
      end else begin
         target_in = TargetNone;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_payload_byte    = word_ff.payload_byte;
   assign rsp_frame_source    = word_ff.frame_source;
   assign rsp_payload_index   = word_ff.payload_index;
   assign rsp_delivery_target = target_ff;
   assign rsp_last_of_frame   = word_ff.last_of_frame;

endmodule

`default_nettype wire

/* sv/addressed_frame_receiver.sv */
// addressed_frame_receiver: top level; register file, parser, queue and output stage.
// Depends on afr_pkg, afr_front, afr_queue, afr_back.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   rx_byte
//   rsp      out        rsp_valid/rsp_stall   payload byte, source, index, target, last
//   csr      in         APB, pready tied high own_address .. second_target_source
//
// One byte per cycle while req_stall is low, set by the phase register of the parser.
// A payload byte is written to the queue, then registered in the output stage for rsp.
// Reset is synchronous, no sweep; all but queue slots and output word reset at once.
// A two-word queue absorbs rsp stalls; req_stall rises only while it is full.
`default_nettype none

module addressed_frame_receiver
   import afr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [7:0]            req_rx_byte,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [7:0]            rsp_payload_byte,
   output      logic [7:0]            rsp_frame_source,
   output      logic [IndexWidth-1:0] rsp_payload_index,
   output      logic [1:0]            rsp_delivery_target,
   output      logic                  rsp_last_of_frame,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready
);

   afr_cfg_type   cfg_ff, cfg_in;
   logic          csr_write;
   logic          step;
   logic          push;
   afr_entry_type push_entry;
   logic          pop;
   logic          full;
   logic          head_valid;
   afr_entry_type head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address          <= 8'd0;
         cfg_ff.source_limit         <= 8'd255;
         cfg_ff.first_target_source  <= 8'd1;
         cfg_ff.second_target_source <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      case (csr_paddr[3:2])
         RegOwnAddress: begin
            csr_prdata = {24'd0, cfg_ff.own_address};
            if (csr_write) cfg_in.own_address = csr_pwdata[7:0];
         end
         RegSourceLimit: begin
            csr_prdata = {24'd0, cfg_ff.source_limit};
            if (csr_write) cfg_in.source_limit = csr_pwdata[7:0];
         end
         RegFirstTarget: begin
            csr_prdata = {24'd0, cfg_ff.first_target_source};
            if (csr_write) cfg_in.first_target_source = csr_pwdata[7:0];
         end
         RegSecondTarget: begin
            csr_prdata = {24'd0, cfg_ff.second_target_source};
            if (csr_write) cfg_in.second_target_source = csr_pwdata[7:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign req_stall = full;
   assign step      = req_valid && !full;

   afr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .push    (push),
      .entry   (push_entry)
   );

   afr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   afr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_frame_source    (rsp_frame_source),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_delivery_target (rsp_delivery_target),
      .rsp_last_of_frame   (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

/* tb/afr_payload_checker.sv */
`timescale 1ns / 1ps
// afr_payload_checker: watches the rx, payload and register ports of addressed_frame_receiver,
// predicts every payload word from the accepted rx bytes and compares it on arrival.
// Depends on afr_pkg.

module afr_payload_checker
   import afr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [7:0]            rsp_payload_byte,
   input  wire logic [7:0]            rsp_frame_source,
   input  wire logic [IndexWidth-1:0] rsp_payload_index,
   input  wire logic [1:0]            rsp_delivery_target,
   input  wire logic                  rsp_last_of_frame,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   input  wire logic                  csr_pready,
   output int                         mismatch_count,
   output int                         words_pending
);

   typedef struct {
      logic [7:0]            payload_byte;
      logic [7:0]            frame_source;
      logic [IndexWidth-1:0] payload_index;
      logic [1:0]            delivery_target;
      logic                  last_of_frame;
   } payload_word_type;

   payload_word_type pending_payload[$];
   afr_cfg_type      regs;
   afr_phase_type    phase;
   logic [7:0]       held_source;
   logic [15:0]      frame_length;
   logic [9:0]       bytes_taken;

   task automatic report_mismatch(input string text);
      $display("%0t mismatch: %s", $time, text);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want, input logic [IndexWidth-1:0] index);
      if (got !== want) begin
         report_mismatch($sformatf("%s at payload index %0d: got %0d, expected %0d",
                                   name, index, got, want));
      end
   endtask

   task automatic drop_frame();
      phase        = PhaseHunt;
      held_source  = 8'd0;
      frame_length = 16'd0;
      bytes_taken  = 10'd0;
   endtask

   task automatic parse_rx_byte(input logic [7:0] rx);
      payload_word_type word;
      case (phase)
         PhaseMark2: phase = (rx == MarkSecond) ? PhaseDest : PhaseHunt;
         PhaseDest: phase = (rx == regs.own_address) ? PhaseSource : PhaseHunt;
         PhaseSource: begin
            if (rx < regs.source_limit) begin
               held_source = rx;
               phase       = PhaseLenHigh;
            end else begin
               phase = PhaseHunt;
            end
         end
         PhaseLenHigh: begin
            frame_length = {rx, 8'd0};
            phase        = PhaseLenLow;
         end
         PhaseLenLow: begin
            frame_length = frame_length + {8'd0, rx};
            if (frame_length == 16'd0 || frame_length > 16'(MaxPayload)) drop_frame();
            else phase = PhasePayload;
         end
         PhasePayload: begin
            word.payload_byte  = rx;
            word.frame_source  = held_source;
            word.payload_index = bytes_taken[IndexWidth-1:0];
            bytes_taken        = bytes_taken + 10'd1;
            word.last_of_frame = ({6'd0, bytes_taken} >= frame_length);
            if (held_source == regs.first_target_source) word.delivery_target = TargetFirst;
            else if (held_source == regs.second_target_source) word.delivery_target = TargetSecond;
            else word.delivery_target = TargetNone;
            pending_payload.push_back(word);
            if (word.last_of_frame) drop_frame();
         end
         default: phase = (rx == MarkFirst) ? PhaseMark2 : PhaseHunt;
      endcase
   endtask

   always @(posedge clock) begin
      payload_word_type want;
      if (reset) begin
         regs.own_address          = 8'd0;
         regs.source_limit         = 8'd255;
         regs.first_target_source  = 8'd1;
         regs.second_target_source = 8'd2;
         mismatch_count            = 0;
         pending_payload.delete();
         drop_frame();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_payload.size() == 0) begin
               report_mismatch($sformatf("payload word %0d with no word expected",
                                         rsp_payload_byte));
            end else begin
               want = pending_payload.pop_front();
               check_field("payload_byte", 16'(rsp_payload_byte), 16'(want.payload_byte),
                           want.payload_index);
               check_field("frame_source", 16'(rsp_frame_source), 16'(want.frame_source),
                           want.payload_index);
               check_field("payload_index", 16'(rsp_payload_index), 16'(want.payload_index),
                           want.payload_index);
               check_field("delivery_target", 16'(rsp_delivery_target),
                           16'(want.delivery_target), want.payload_index);
               check_field("last_of_frame", 16'(rsp_last_of_frame), 16'(want.last_of_frame),
                           want.payload_index);
            end
         end
         // rx byte first: a register write at the same edge applies from the next byte
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               RegOwnAddress:   regs.own_address          = csr_pwdata[7:0];
               RegSourceLimit:  regs.source_limit         = csr_pwdata[7:0];
               RegFirstTarget:  regs.first_target_source  = csr_pwdata[7:0];
               RegSecondTarget: regs.second_target_source = csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
      words_pending = pending_payload.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: feeds rx bytes and register writes to addressed_frame_receiver, stalls the
// payload side at random and prints the verdict; depends on afr_pkg, dut and checker.

module testbench;
   import afr_pkg::*;

   localparam int HoldOffCycles = 64;
   localparam int QuietLimit    = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_byte = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_payload_byte;
   logic [7:0]            rsp_frame_source;
   logic [IndexWidth-1:0] rsp_payload_index;
   logic [1:0]            rsp_delivery_target;
   logic                  rsp_last_of_frame;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [3:0]            csr_paddr = 4'd0;
   logic [31:0]           csr_pwdata = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    words_pending;
   bit                    idle_enable = 1'b1;
   bit                    hold_off_now = 1'b0;
   int                    bytes_sent = 0;
   int                    quiet_cycles = 0;
   afr_cfg_type           shadow;

   addressed_frame_receiver dut (.*);

   afr_payload_checker payload_check (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // payload side stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(negedge clock);
            hold_off_now = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return MarkFirst;
         1: return MarkSecond;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                             input logic [15:0] len_field, input int body);
      send_byte(MarkFirst);
      send_byte(MarkSecond);
      send_byte(dest);
      send_byte(src);
      send_byte(len_field[15:8]);
      send_byte(len_field[7:0]);
      repeat (body) send_byte(pick_byte());
   endtask

   task automatic send_random_frame();
      logic [7:0]  src;
      logic [7:0]  bad;
      logic [15:0] len;
      int          kind;
      int          bias;
      kind = $urandom_range(0, 19);
      bias = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) len = 16'($urandom_range(9, 48));
      else len = 16'($urandom_range(1, 8));
      if (shadow.source_limit == 8'd0) src = 8'($urandom_range(0, 255));
      else src = 8'($urandom_range(0, shadow.source_limit - 1));
      if (bias == 0 && shadow.first_target_source < shadow.source_limit)
         src = shadow.first_target_source;
      else if (bias == 1 && shadow.second_target_source < shadow.source_limit)
         src = shadow.second_target_source;
      if (kind < 13) begin
         send_frame(shadow.own_address, src, len, len);
      end else begin
         case (kind)
            13: repeat ($urandom_range(1, 6)) send_byte(pick_byte());
            14: begin
               bad = pick_byte();
               if (bad == MarkSecond) bad = MarkFirst;
               send_byte(MarkFirst);
               send_byte(bad);
            end
            15: send_frame(shadow.own_address ^ 8'($urandom_range(1, 255)), src, len, len);
            16: send_frame(shadow.own_address, 8'($urandom_range(shadow.source_limit, 255)),
                           len, len);
            17: send_frame(shadow.own_address, src, 16'd0, $urandom_range(0, 3));
            18: send_frame(shadow.own_address, src,
                           16'($urandom_range(MaxPayload + 1, 65535)), $urandom_range(0, 3));
            default: send_frame(shadow.own_address, src, len, $urandom_range(0, len - 1));
         endcase
      end
   endtask

   task automatic send_random(input int count);
      int stop;
      stop = bytes_sent + count;
      while (bytes_sent < stop) send_random_frame();
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_pending == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      logic [31:0] filler;
      filler = $urandom();
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {index, 2'b00};
      csr_pwdata <= {filler[31:8], value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] own, input logic [7:0] limit,
                             input logic [7:0] first, input logic [7:0] second);
      drain();
      write_register(RegOwnAddress, own);
      write_register(RegSourceLimit, limit);
      write_register(RegFirstTarget, first);
      write_register(RegSecondTarget, second);
      shadow.own_address          = own;
      shadow.source_limit         = limit;
      shadow.first_target_source  = first;
      shadow.second_target_source = second;
   endtask

   initial begin
      logic [7:0] lim;
      shadow.own_address          = 8'd0;
      shadow.source_limit         = 8'd255;
      shadow.first_target_source  = 8'd1;
      shadow.second_target_source = 8'd2;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_frame(8'd0, 8'd1, 16'd1, 1);
      send_byte(MarkFirst);
      send_byte(MarkFirst);
      send_byte(MarkSecond);
      send_frame(8'd0, 8'd2, 16'd0, 0);
      send_frame(8'd0, 8'd3, 16'(MaxPayload + 1), 0);
      send_frame(8'd1, 8'd1, 16'd1, 1);
      send_frame(8'd0, 8'd254, 16'd2, 2);
      send_frame(8'd0, 8'd255, 16'd1, 1);

      // long hold-off on the payload side fills the queue and stalls rx
      hold_off_now = 1'b1;
      send_frame(8'd0, 8'd1, 16'd40, 40);
      send_frame(8'd0, 8'd2, 16'(MaxPayload), MaxPayload);
      send_random(300);

      set_config(8'hFF, 8'h00, 8'h00, 8'hFF);
      send_random(80);

      set_config(MarkFirst, 8'h01, 8'h00, 8'h00);
      send_random(300);
      // leave a frame open across the next register change
      send_frame(MarkFirst, 8'h00, 16'd3, 1);

      lim = 8'($urandom_range(1, 255));
      set_config(8'($urandom_range(0, 255)), lim, 8'($urandom_range(0, lim - 1)),
                 8'($urandom_range(0, lim - 1)));
      send_random(400);

      set_config(8'($urandom_range(0, 255)), 8'hFF, 8'($urandom_range(0, 254)),
                 8'($urandom_range(0, 254)));
      idle_enable = 1'b0;
      send_random(450);

      drain();
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* addressed_frame_receiver.f */
sv/afr_pkg.sv
sv/afr_front.sv
sv/afr_queue.sv
sv/afr_back.sv
sv/addressed_frame_receiver.sv
tb/afr_payload_checker.sv
tb/testbench.sv
